>>> src/wps_pkg.sv
// Shared types and constants for the RIFF/WAVE PCM stream parser.
// Holds the byte and result transfer structs, the status codes and the magic words.
// Depends on nothing else.
package wps_pkg;

  localparam int OffsetWidth = 34;
  localparam logic [OffsetWidth-1:0] OffsetMax = {OffsetWidth{1'b1}};
  localparam logic [OffsetWidth-1:0] FirstChunkOffset = 34'd12;

  // Magic words, first file byte in the low byte.
  localparam logic [31:0] RiffTag = 32'h4646_4952;
  localparam logic [31:0] WaveTag = 32'h4556_4157;
  // Chunk id as shifted in, first byte in the high byte.
  localparam logic [31:0] DataId  = 32'h6461_7461;

  localparam logic [15:0] FormatPcm = 16'd1;
  localparam logic [15:0] Depth8    = 16'd8;
  localparam logic [15:0] Depth16   = 16'd16;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_MAGIC    = 3'd2,
    STATUS_NOT_PCM  = 3'd3,
    STATUS_DEPTH    = 3'd4,
    STATUS_NO_DATA  = 3'd5,
    STATUS_EMPTY    = 3'd6,
    STATUS_OVERLAP  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               sample_valid;
    logic               finished;
    logic [2:0]         status_code;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [15:0]        depth_bits;
  } result_item_t;

endpackage

>>> src/wav_pcm_stream_parser.sv
// RIFF/WAVE PCM stream parser, top level.
// Parses a byte stream into header fields, a status and signed 16-bit samples.
// Depends on wps_pkg for the transfer structs, status codes and magic words.
//
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_data) carries one file byte
//   per transfer, with end_of_buffer set on the final byte of a file. The
//   result channel (result_valid, result_stall, result_data) carries a result
//   for every byte that completes a sample or ends the file; other bytes give
//   no result transfer. Samples seen before a nonzero final status should be
//   discarded by the consumer.
//   A result is presented in the cycle after its byte is
//   transferred. Throughput is one byte per cycle; the whole per-byte update
//   (header capture, chunk walk and sample build) is a single pass of logic
//   between the byte transfer and the result register.
//   When the receiver stalls while a result is pending, byte_stall is raised
//   and the pending result holds until it is taken. Bytes keep flowing while
//   the result register is empty or being drained in the same cycle.
//   Reset clears the parser to the start of a new file and empties the result
//   register. After the final byte of a file the parser returns to the same
//   state, so the next byte begins a new file.
module wav_pcm_stream_parser
  import wps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_data
);

  // Parser state.
  logic [OffsetWidth-1:0] byte_offset;
  logic                   magic_ok;
  logic [15:0]            format_word;
  logic [15:0]            channels_word;
  logic [31:0]            rate_word;
  logic [15:0]            depth_word;
  logic [OffsetWidth-1:0] next_chunk_offset;
  logic [31:0]            chunk_id_shift;
  logic [31:0]            chunk_size_shift;
  logic                   data_found;
  logic [31:0]            data_bytes_left;
  logic [7:0]             low_byte_hold;
  logic                   pair_phase;
  logic                   any_sample;
  logic                   overlap_flag;

  // State after the current byte, before the end-of-file return to reset.
  logic [OffsetWidth-1:0] byte_offset_next;
  logic                   magic_ok_next;
  logic [15:0]            format_word_next;
  logic [15:0]            channels_word_next;
  logic [31:0]            rate_word_next;
  logic [15:0]            depth_word_next;
  logic [OffsetWidth-1:0] next_chunk_offset_next;
  logic [31:0]            chunk_id_shift_next;
  logic [31:0]            chunk_size_shift_next;
  logic                   data_found_next;
  logic [31:0]            data_bytes_left_next;
  logic [7:0]             low_byte_hold_next;
  logic                   pair_phase_next;
  logic                   any_sample_next;
  logic                   overlap_flag_next;

  logic                   accept;
  logic [7:0]             b;
  logic                   last;
  logic                   not_saturated;
  logic [OffsetWidth:0]   chunk_diff;
  logic                   in_header;
  logic                   header_id_part;
  logic                   header_done;
  logic [OffsetWidth:0]   chunk_end;
  logic                   emit_sample;
  logic [15:0]            sample_bits;
  status_t                status;
  result_item_t           result_next;

  // A result waiting on a stalled receiver blocks the next byte; otherwise
  // the result register is free to take a new result this cycle.
  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  assign b    = byte_data.in_byte;
  assign last = byte_data.end_of_buffer;

  assign not_saturated = (byte_offset != OffsetMax);

  // Position relative to the current chunk header. The borrow of the
  // subtraction is the "not yet at the header" test.
  assign chunk_diff     = {1'b0, byte_offset} - {1'b0, next_chunk_offset};
  assign in_header      = !chunk_diff[OffsetWidth];
  assign header_id_part = (chunk_diff[OffsetWidth-1:2] == '0);
  assign header_done    = (chunk_diff[OffsetWidth-1:0] == OffsetWidth'(7));

  // Start of the following chunk: past this header, the payload and an odd pad byte.
  // At the last header byte the size word is this byte over the upper three.
  assign chunk_end = {1'b0, byte_offset} + (OffsetWidth+1)'(1)
                   + (OffsetWidth+1)'({b, chunk_size_shift[31:8]})
                   + (OffsetWidth+1)'(chunk_size_shift[8]);

  always_comb begin
    byte_offset_next       = not_saturated ? byte_offset + OffsetWidth'(1) : byte_offset;
    magic_ok_next          = magic_ok;
    format_word_next       = format_word;
    channels_word_next     = channels_word;
    rate_word_next         = rate_word;
    depth_word_next        = depth_word;
    next_chunk_offset_next = next_chunk_offset;
    chunk_id_shift_next    = chunk_id_shift;
    chunk_size_shift_next  = chunk_size_shift;
    data_found_next        = data_found;
    data_bytes_left_next   = data_bytes_left;
    low_byte_hold_next     = low_byte_hold;
    pair_phase_next        = pair_phase;
    overlap_flag_next      = overlap_flag;
    emit_sample            = 1'b0;
    sample_bits            = '0;

    // Magic words at offsets 0 to 3 and 8 to 11.
    if (byte_offset[OffsetWidth-1:2] == '0 && b != RiffTag[{byte_offset[1:0], 3'b000} +: 8]) begin
      magic_ok_next = 1'b0;
    end
    if (byte_offset[OffsetWidth-1:2] == (OffsetWidth-2)'(2) &&
        b != WaveTag[{byte_offset[1:0], 3'b000} +: 8]) begin
      magic_ok_next = 1'b0;
    end

    // Fixed-offset header words, little-endian.
    if (byte_offset[OffsetWidth-1:1] == (OffsetWidth-1)'(10)) begin
      format_word_next[{byte_offset[0], 3'b000} +: 8] =
        format_word[{byte_offset[0], 3'b000} +: 8] | b;
    end else if (byte_offset[OffsetWidth-1:1] == (OffsetWidth-1)'(11)) begin
      channels_word_next[{byte_offset[0], 3'b000} +: 8] =
        channels_word[{byte_offset[0], 3'b000} +: 8] | b;
    end else if (byte_offset[OffsetWidth-1:2] == (OffsetWidth-2)'(6)) begin
      rate_word_next[{byte_offset[1:0], 3'b000} +: 8] =
        rate_word[{byte_offset[1:0], 3'b000} +: 8] | b;
    end else if (byte_offset[OffsetWidth-1:1] == (OffsetWidth-1)'(17)) begin
      depth_word_next[{byte_offset[0], 3'b000} +: 8] =
        depth_word[{byte_offset[0], 3'b000} +: 8] | b;
    end

    if (data_found) begin
      // Payload of the data chunk, clamped to the bytes that arrive.
      if (data_bytes_left != '0) begin
        data_bytes_left_next = data_bytes_left - 32'd1;
        if (depth_word_next == Depth16) begin
          if (!pair_phase) begin
            low_byte_hold_next = b;
            pair_phase_next    = 1'b1;
          end else begin
            sample_bits     = {b, low_byte_hold};
            pair_phase_next = 1'b0;
            emit_sample     = 1'b1;
          end
        end else if (depth_word_next == Depth8) begin
          sample_bits = {~b[7], b[6:0], 8'h00};
          emit_sample = 1'b1;
        end
      end
    end else if (not_saturated && in_header) begin
      // Chunk header: id shifted in high first, size shifted in low first.
      if (header_id_part) begin
        chunk_id_shift_next = {chunk_id_shift[23:0], b};
      end else begin
        chunk_size_shift_next = {b, chunk_size_shift[31:8]};
      end
      if (header_done) begin
        if (chunk_id_shift_next == DataId) begin
          data_found_next = 1'b1;
          // A payload starting before offset 36 would overlap the format fields.
          if (byte_offset < OffsetWidth'(35)) begin
            overlap_flag_next    = 1'b1;
            data_bytes_left_next = '0;
          end else begin
            data_bytes_left_next = chunk_size_shift_next;
          end
        end else if (chunk_end > {1'b0, OffsetMax}) begin
          next_chunk_offset_next = OffsetMax;
        end else begin
          next_chunk_offset_next = chunk_end[OffsetWidth-1:0];
        end
      end
    end

    any_sample_next = any_sample || emit_sample;
  end

  // Final status, first applicable error in file order.
  always_comb begin
    if (byte_offset < OffsetWidth'(43)) begin
      status = STATUS_SHORT;
    end else if (!magic_ok_next) begin
      status = STATUS_MAGIC;
    end else if (format_word_next != FormatPcm) begin
      status = STATUS_NOT_PCM;
    end else if (depth_word_next != Depth16 && depth_word_next != Depth8) begin
      status = STATUS_DEPTH;
    end else if (!data_found_next) begin
      status = STATUS_NO_DATA;
    end else if (overlap_flag_next) begin
      status = STATUS_OVERLAP;
    end else if (!any_sample_next) begin
      status = STATUS_EMPTY;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result_next.sample_value  = emit_sample ? sample_bits : '0;
    result_next.sample_valid  = emit_sample;
    result_next.finished      = last;
    result_next.status_code   = last ? status : STATUS_OK;
    result_next.channel_count = last ? channels_word_next : '0;
    result_next.rate_hz       = last ? rate_word_next : '0;
    result_next.depth_bits    = last ? depth_word_next : '0;
  end

  // Parser state. The final byte of a file returns everything to reset values.
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      byte_offset       <= '0;
      magic_ok          <= 1'b1;
      format_word       <= '0;
      channels_word     <= '0;
      rate_word         <= '0;
      depth_word        <= '0;
      next_chunk_offset <= FirstChunkOffset;
      chunk_id_shift    <= '0;
      chunk_size_shift  <= '0;
      data_found        <= 1'b0;
      data_bytes_left   <= '0;
      low_byte_hold     <= '0;
      pair_phase        <= 1'b0;
      any_sample        <= 1'b0;
      overlap_flag      <= 1'b0;
    end else if (accept) begin
      byte_offset       <= byte_offset_next;
      magic_ok          <= magic_ok_next;
      format_word       <= format_word_next;
      channels_word     <= channels_word_next;
      rate_word         <= rate_word_next;
      depth_word        <= depth_word_next;
      next_chunk_offset <= next_chunk_offset_next;
      chunk_id_shift    <= chunk_id_shift_next;
      chunk_size_shift  <= chunk_size_shift_next;
      data_found        <= data_found_next;
      data_bytes_left   <= data_bytes_left_next;
      low_byte_hold     <= low_byte_hold_next;
      pair_phase        <= pair_phase_next;
      any_sample        <= any_sample_next;
      overlap_flag      <= overlap_flag_next;
    end
  end

  // Result register. It is loaded on every byte transfer; a byte without a
  // result leaves it empty, and a taken result frees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= emit_sample || last;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result_next;
    end
  end

endmodule

>>> bench/wav_pcm_stream_parser_tb.sv
// Self-checking bench for wav_pcm_stream_parser: builds RIFF/WAVE files byte by byte,
// predicts every sample and final status, and compares each result transfer.
// Depends on wps_pkg and the wav_pcm_stream_parser RTL only.
module wav_pcm_stream_parser_tb
  import wps_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 11;
  localparam int TotalBytes  = 1600;
  localparam int CycleLimit  = 1_000_000;
  localparam int PrintLimit  = 100;

  // A file must hold at least the 44-byte canonical header to be judged at all.
  localparam int MinFileBytes = 44;
  // Offset where the fixed header words end; payload before it collides with them.
  localparam int HeaderEnd    = 36;

  // Chunk ids as they appear in the file, first byte in the high byte.
  localparam logic [31:0] FmtId      = 32'h666d_7420;
  localparam logic [31:0] ListId     = 32'h4c49_5354;
  localparam logic [31:0] NearDataId = 32'h6461_7462;

  typedef struct {
    byte_item_t item;
    bit         drain_first;  // hold this byte back until every result has arrived
  } feed_entry_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_item_t   byte_data = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_data;

  wav_pcm_stream_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model state. It mirrors what the block has to remember between
  // bytes of one file and is cleared after each final byte.
  // ---------------------------------------------------------------------------
  logic [OffsetWidth-1:0] cur_offset;
  logic                   magic_good;
  logic [15:0]            fmt_field;
  logic [15:0]            chan_field;
  logic [31:0]            rate_field;
  logic [15:0]            depth_field;
  logic [OffsetWidth-1:0] chunk_start;
  logic [31:0]            id_shift;
  logic [31:0]            size_shift;
  logic                   in_payload;
  logic [31:0]            payload_left;
  logic [7:0]             held_low;
  logic                   half_pair;
  logic                   made_sample;
  logic                   overlapped;

  result_item_t parsed_results[$];  // results still owed by the block, oldest first
  feed_entry_t  byte_feed[$];       // bytes not yet presented to the block
  logic [7:0]   file_bytes[$];      // file under construction

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  bytes_sent = 0;
  int  bytes_total = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  logic calm;

  // In a recurring window both sides run flat out for a while, so that
  // back-to-back transfers are exercised as well as the gaps.
  assign calm = (cycle_count % 4000) < 800;

  task automatic clear_parser();
    cur_offset   = '0;
    magic_good   = 1'b1;
    fmt_field    = '0;
    chan_field   = '0;
    rate_field   = '0;
    depth_field  = '0;
    chunk_start  = FirstChunkOffset;
    id_shift     = '0;
    size_shift   = '0;
    in_payload   = 1'b0;
    payload_left = '0;
    held_low     = '0;
    half_pair    = 1'b0;
    made_sample  = 1'b0;
    overlapped   = 1'b0;
  endtask

  // The first failing check in file order wins. Note that a short file is
  // judged by the offset of its final byte, before anything else.
  function automatic status_t file_status(input logic [OffsetWidth-1:0] at);
    if (at < MinFileBytes - 1) return STATUS_SHORT;
    if (!magic_good) return STATUS_MAGIC;
    if (fmt_field != FormatPcm) return STATUS_NOT_PCM;
    if (depth_field != Depth16 && depth_field != Depth8) return STATUS_DEPTH;
    if (!in_payload) return STATUS_NO_DATA;
    if (overlapped) return STATUS_OVERLAP;
    if (!made_sample) return STATUS_EMPTY;
    return STATUS_OK;
  endfunction

  // Advances the model by one accepted byte and queues the result it causes.
  task automatic parse_byte(input byte_item_t it);
    logic [OffsetWidth-1:0] at;
    logic [OffsetWidth-1:0] rel;
    logic [OffsetWidth:0]   next_at;
    logic [7:0]             b;
    logic                   got;
    result_item_t           r;
    at  = cur_offset;
    b   = it.in_byte;
    got = 1'b0;
    r   = '0;

    // Magic words sit at offsets 0..3 and 8..11; the low two offset bits
    // select the expected byte in both cases.
    if (at < 4 && b != RiffTag[8 * at[1:0] +: 8]) magic_good = 1'b0;
    if (at >= 8 && at < 12 && b != WaveTag[8 * at[1:0] +: 8]) magic_good = 1'b0;

    // Fixed little-endian header words.
    if (at >= 20 && at < 22)
      fmt_field |= 16'(b) << (8 * (at - 20));
    else if (at >= 22 && at < 24)
      chan_field |= 16'(b) << (8 * (at - 22));
    else if (at >= 24 && at < 28)
      rate_field |= 32'(b) << (8 * (at - 24));
    else if (at >= 34 && at < 36)
      depth_field |= 16'(b) << (8 * (at - 34));

    if (in_payload) begin
      // Payload bytes are counted even when the depth is unsupported; bytes
      // beyond the declared size are ignored.
      if (payload_left != 0) begin
        payload_left--;
        if (depth_field == Depth16) begin
          if (!half_pair) begin
            held_low  = b;
            half_pair = 1'b1;
          end else begin
            r.sample_value = {b, held_low};
            half_pair      = 1'b0;
            got            = 1'b1;
          end
        end else if (depth_field == Depth8) begin
          r.sample_value = {b ^ 8'h80, 8'h00};
          got            = 1'b1;
        end
      end
    end else if (at < OffsetMax && at >= chunk_start) begin
      // Chunk header walk: four id bytes shifted in big-endian, then four
      // size bytes shifted in little-endian.
      rel = at - chunk_start;
      if (rel < 4)
        id_shift = {id_shift[23:0], b};
      else
        size_shift = {b, size_shift[31:8]};
      if (rel == 7) begin
        if (id_shift == DataId) begin
          in_payload = 1'b1;
          if (at + 1 < HeaderEnd) begin
            overlapped   = 1'b1;
            payload_left = '0;
          end else begin
            payload_left = size_shift;
          end
        end else begin
          // Skip the chunk body plus its pad byte when the size is odd.
          next_at = {1'b0, at} + 1 + (OffsetWidth + 1)'(size_shift)
                    + (OffsetWidth + 1)'(size_shift[0]);
          chunk_start = (next_at > {1'b0, OffsetMax}) ? OffsetMax
                                                      : next_at[OffsetWidth-1:0];
        end
      end
    end

    if (got) made_sample = 1'b1;
    if (at < OffsetMax) cur_offset = at + 1;

    if (got || it.end_of_buffer) begin
      r.sample_valid = got;
      r.finished     = it.end_of_buffer;
      if (it.end_of_buffer) begin
        r.status_code   = file_status(at);
        r.channel_count = chan_field;
        r.rate_hz       = rate_field;
        r.depth_bits    = depth_field;
      end
      parsed_results.push_back(r);
    end
    if (it.end_of_buffer) clear_parser();
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintLimit)
      $display("[%0t] result %0d: %s", $realtime, results_checked, what);
    mismatch_count++;
  endtask

  task automatic check_result(input result_item_t got);
    result_item_t want;
    if (parsed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result transfer %h", got));
      return;
    end
    want = parsed_results.pop_front();
    if (got.sample_value !== want.sample_value)
      report_mismatch($sformatf("sample_value %0d, expected %0d",
                                got.sample_value, want.sample_value));
    if (got.sample_valid !== want.sample_valid)
      report_mismatch($sformatf("sample_valid %b, expected %b",
                                got.sample_valid, want.sample_valid));
    if (got.finished !== want.finished)
      report_mismatch($sformatf("finished %b, expected %b", got.finished, want.finished));
    if (got.status_code !== want.status_code)
      report_mismatch($sformatf("status_code %0d, expected %0d",
                                got.status_code, want.status_code));
    if (got.channel_count !== want.channel_count)
      report_mismatch($sformatf("channel_count %h, expected %h",
                                got.channel_count, want.channel_count));
    if (got.rate_hz !== want.rate_hz)
      report_mismatch($sformatf("rate_hz %h, expected %h", got.rate_hz, want.rate_hz));
    if (got.depth_bits !== want.depth_bits)
      report_mismatch($sformatf("depth_bits %h, expected %h",
                                got.depth_bits, want.depth_bits));
    results_checked++;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // File construction helpers.
  // ---------------------------------------------------------------------------
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic put_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(id[8 * i +: 8]);
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic put_chunk(input logic [31:0] id, input logic [31:0] size, input int n);
    put_id(id);
    put_le(size, 4);
    put_random(n);
  endtask

  // Starts a fresh file with the canonical 36-byte RIFF/WAVE/fmt header.
  task automatic start_wave(input logic [15:0] fmt, input logic [15:0] chans,
                            input logic [31:0] rate, input logic [15:0] depth);
    file_bytes.delete();
    put_le(RiffTag, 4);
    put_le($urandom, 4);
    put_le(WaveTag, 4);
    put_id(FmtId);
    put_le(32'd16, 4);
    put_le(32'(fmt), 2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(depth), 2);
  endtask

  // Queues the finished file; end_of_buffer marks its last byte.
  task automatic send_file(input bit drain);
    feed_entry_t e;
    foreach (file_bytes[i]) begin
      e.item.in_byte       = file_bytes[i];
      e.item.end_of_buffer = (i == file_bytes.size() - 1);
      e.drain_first        = drain && (i == 0);
      byte_feed.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. The model is advanced on every accepted transfer; a new byte
  // is only presented once the current one has gone, so a stalled payload
  // stays put.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        parse_byte(byte_data);
        bytes_sent++;
      end
      if (!byte_valid || !byte_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (byte_feed.size() > 0 &&
                     (!byte_feed[0].drain_first || parsed_results.size() == 0)) begin
          byte_data  <= byte_feed[0].item;
          byte_valid <= 1'b1;
          void'(byte_feed.pop_front());
          gap_left = calm ? 0 : pick_gap();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Stall bursts are independent of result_valid, so they land
  // on every phase of a file, including the final status transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) check_result(result_data);
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // Watchdog against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int sz;
    int kind;
    int nbytes;
    int keep;
    logic [31:0] dsz;
    logic [15:0] fmt;
    logic [15:0] depth;

    clear_parser();

    // --- Directed files ------------------------------------------------------

    // Plain 16-bit file: sample extremes, then an unpaired final byte that is
    // dropped, so the status arrives without a sample.
    start_wave(FormatPcm, 16'd2, 32'd44100, Depth16);
    put_chunk(DataId, 32'd9, 0);
    put_le(32'h7fff_0000, 4);
    put_le(32'hffff_8000, 4);
    put_random(1);
    send_file(1'b0);

    // 8-bit file with the widest header words; the final byte completes a
    // sample, so one transfer carries both the sample and the status.
    start_wave(FormatPcm, 16'hffff, 32'hffff_ffff, Depth8);
    put_chunk(DataId, 32'd4, 0);
    put_le(32'h7fff_8000, 4);
    send_file(1'b0);

    // 16-bit file whose last byte closes a pair; zero header words.
    start_wave(FormatPcm, 16'd0, 32'd0, Depth16);
    put_chunk(DataId, 32'd4, 0);
    put_le(32'habcd_1234, 4);
    send_file(1'b1);

    // Odd-sized chunk with its pad byte, and an id two bits away from data,
    // before the real data chunk.
    start_wave(FormatPcm, 16'd1, 32'd8000, Depth16);
    put_chunk(ListId, 32'd3, 3);
    put_random(1);
    put_chunk(NearDataId, 32'd0, 0);
    put_chunk(DataId, 32'd6, 6);
    send_file(1'b0);

    // Declared size far beyond the bytes present: payload is cut at the end.
    start_wave(FormatPcm, 16'd1, 32'd22050, Depth8);
    put_chunk(DataId, 32'hffff_ffff, 5);
    send_file(1'b0);

    // Bytes after the declared payload are not samples.
    start_wave(FormatPcm, 16'd1, 32'd11025, Depth16);
    put_chunk(DataId, 32'd2, 8);
    send_file(1'b0);

    // Exactly 44 bytes with an empty data chunk: long enough, but no samples.
    start_wave(FormatPcm, 16'd2, 32'd48000, Depth16);
    put_chunk(DataId, 32'd0, 0);
    send_file(1'b0);

    // One byte short of the minimum, and a lone byte.
    start_wave(FormatPcm, 16'd2, 32'd48000, Depth16);
    put_chunk(DataId, 32'd0, 0);
    void'(file_bytes.pop_back());
    send_file(1'b0);
    file_bytes.delete();
    put_le(RiffTag, 1);
    send_file(1'b0);

    // Short wins over a bad magic word.
    file_bytes.delete();
    put_random(10);
    file_bytes[0] = 8'h00;
    send_file(1'b0);

    // Bad RIFF word on an otherwise good file.
    start_wave(FormatPcm, 16'd1, 32'd8000, Depth8);
    put_chunk(DataId, 32'd3, 3);
    file_bytes[1] = 8'h58;
    send_file(1'b0);

    // Bad WAVE word together with a non-PCM format: magic is reported.
    start_wave(16'd2, 16'd1, 32'd8000, Depth8);
    put_chunk(DataId, 32'd3, 3);
    file_bytes[10] = 8'h00;
    send_file(1'b0);

    // Non-PCM format with good magic.
    start_wave(16'd3, 16'd1, 32'd96000, Depth16);
    put_chunk(DataId, 32'd4, 4);
    send_file(1'b0);

    // Unsupported depth: payload is counted but yields nothing.
    start_wave(FormatPcm, 16'd2, 32'd44100, 16'd24);
    put_chunk(DataId, 32'd6, 6);
    send_file(1'b0);

    // No data chunk at all.
    start_wave(FormatPcm, 16'd2, 32'd44100, Depth16);
    put_chunk(ListId, 32'd10, 10);
    send_file(1'b0);

    // Data chunk header cut off by the end of the file does not count.
    start_wave(FormatPcm, 16'd1, 32'd48000, Depth16);
    put_chunk(ListId, 32'd4, 4);
    put_id(DataId);
    put_le(32'd16, 2);
    send_file(1'b0);

    // Data chunk placed right after WAVE: its payload would overlap the fixed
    // header words, which still parse as a valid 16-bit PCM header.
    file_bytes.delete();
    put_le(RiffTag, 4);
    put_le($urandom, 4);
    put_le(WaveTag, 4);
    put_id(DataId);
    put_le(32'd100, 4);
    put_le(32'(FormatPcm), 2);
    put_le(32'd2, 2);
    put_le(32'd16000, 4);
    put_le($urandom, 4);
    put_le(32'd4, 2);
    put_le(32'(Depth16), 2);
    put_random(10);
    send_file(1'b0);

    // --- Random files --------------------------------------------------------
    // They fill the feed up to the planned byte count. Most are well-formed
    // with random content so the chunk walk and sample paths are reached;
    // some are corrupted or cut short, a few pure noise.
    while (byte_feed.size() < TotalBytes) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        file_bytes.delete();
        if ($urandom_range(0, 1) == 1) put_le(RiffTag, 4);
        put_random($urandom_range(1, 70));
      end else begin
        fmt = ($urandom_range(0, 9) != 0) ? FormatPcm : 16'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: depth = Depth16;
          4, 5, 6:    depth = Depth8;
          7:          depth = 16'd24;
          8:          depth = 16'd0;
          default:    depth = 16'($urandom);
        endcase
        start_wave(fmt, 16'($urandom), $urandom, depth);
        repeat ($urandom_range(0, 2)) begin
          sz = $urandom_range(0, 7);
          put_chunk(($urandom_range(0, 3) == 0) ? $urandom : ListId, sz, sz);
          if (sz % 2 == 1) put_random(1);
        end
        case ($urandom_range(0, 19))
          0:       dsz = 32'd0;
          1:       dsz = $urandom;
          default: dsz = $urandom_range(1, 40);
        endcase
        nbytes = (dsz > 48) ? $urandom_range(0, 40) : int'(dsz);
        case ($urandom_range(0, 4))
          0:       nbytes = $urandom_range(0, nbytes);
          1:       nbytes = nbytes + $urandom_range(1, 6);
          default: ;
        endcase
        put_chunk(DataId, dsz, nbytes);
        if ($urandom_range(0, 11) == 0)
          file_bytes[$urandom_range(0, MinFileBytes - 1)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 11) == 0) begin
          keep = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
      end
      send_file($urandom_range(0, 19) == 0);
    end

    bytes_total = byte_feed.size();

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Let every byte go, then every owed result, then keep the clock running
    // idle to catch stray transfers. The block answers in the cycle after a byte.
    while (bytes_sent != bytes_total) @(posedge clk);
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && parsed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
